// ----- hw/rtl/alfsm_pkg.sv -----
// Shared types and codes for the audio level and frame stats meter.
// No dependencies. Used by alfsm_shift_sub and the top level.
package alfsm_pkg;

  typedef enum logic [2:0] {
    REQ_PCM      = 3'd0,
    REQ_FRAME_OK = 3'd1,
    REQ_FRAME_ER = 3'd2,
    REQ_REPORT   = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_e;

  typedef struct packed {
    logic        [2:0]  req_type;
    logic signed [15:0] pcm_sample;
    logic        [19:0] decode_time_us;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rms_level;
    logic [15:0] peak_level;
    logic [31:0] ok_frames;
    logic [31:0] err_frames;
    logic [31:0] err_frames_total;
    logic [31:0] avg_decode_us;
    logic [19:0] max_decode_us;
  } out_item_t;

  typedef enum logic {
    SU_DIV  = 1'b0,
    SU_SQRT = 1'b1
  } su_op_e;

  // Request into the shared shift/subtract unit.
  typedef struct packed {
    logic   go;
    su_op_e op;
  } su_req_t;

  // Status back from the unit.
  typedef struct packed {
    logic busy;
    logic done;
  } su_stat_t;

  localparam int unsigned DivSteps  = 64;
  localparam int unsigned SqrtSteps = 32;

endpackage

// ----- hw/rtl/audio_level_and_frame_stats_meter.sv -----
// Audio level and frame statistics meter: top level with accumulators,
// report sequencer and output register. Uses alfsm_pkg, alfsm_shift_sub.
//
//   port         dir  payload      handshake
//   in_data_i    in   in_item_t    in_valid_i / in_stall_o
//   out_data_o   out  out_item_t   out_valid_o / out_stall_i
//
// Sample, frame-ok, frame-error and clear-all items never hold off input.
// A report item holds off input until its result is loaded; when both counts
// are nonzero it runs mean divide (64 steps), square root (32 steps) and
// average divide (64 steps), each with a load and a hand-off on the one
// shift/subtract unit, plus the send. No samples skips divide and root, no ok
// frames skips the average divide, neither leaves only the send. The result sits in the output
// register until taken; a new report finishing while that register is still
// stalled waits for it. Reset clears all counts.
module audio_level_and_frame_stats_meter import alfsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_ROOT,
    ST_AVG,
    ST_SEND
  } state_e;

  state_e      state_q;

  // interval statistics
  logic [63:0] sq_sum_q;
  logic [31:0] n_samp_q;
  logic [15:0] peak_q;
  logic [31:0] ok_q;
  logic [31:0] err_q;
  logic [31:0] err_tot_q;
  logic [31:0] dsum_q;
  logic [19:0] dmax_q;

  // report snapshot
  logic [31:0] snap_ok_q;
  logic [31:0] snap_dsum_q;
  out_item_t   pend_q;
  out_item_t   out_q;
  logic        out_valid_q;

  logic        su_go_q;
  logic        su_go_d;
  su_op_e      su_op_q;
  logic [63:0] su_x_q;
  logic [31:0] su_d_q;
  su_req_t     su_req;
  su_stat_t    su_stat;
  logic [63:0] su_res;

  logic        in_xfer;
  logic [15:0] mag;
  logic [31:0] mag_sq;
  logic [15:0] rms_sat;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign mag    = in_data_i.pcm_sample[15] ? 16'(-in_data_i.pcm_sample)
                                           : in_data_i.pcm_sample;
  assign mag_sq = {16'd0, mag} * {16'd0, mag};
  assign rms_sat = (|su_res[31:16]) ? 16'hFFFF : su_res[15:0];

  // unit launch: report with work to do, then each hand-off between steps
  assign su_go_d = ((state_q == ST_IDLE) && in_xfer && (in_data_i.req_type == REQ_REPORT) &&
                    ((n_samp_q != 32'd0) || (ok_q != 32'd0))) ||
                   ((state_q == ST_MEAN) && su_stat.done) ||
                   ((state_q == ST_ROOT) && su_stat.done && (snap_ok_q != 32'd0));

  assign su_req.go = su_go_q;
  assign su_req.op = su_op_q;

  alfsm_shift_sub u_shift_sub (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (su_req),
    .x_i    (su_x_q),
    .d_i    (su_d_q),
    .stat_o (su_stat),
    .res_o  (su_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sq_sum_q    <= '0;
      n_samp_q    <= '0;
      peak_q      <= '0;
      ok_q        <= '0;
      err_q       <= '0;
      err_tot_q   <= '0;
      dsum_q      <= '0;
      dmax_q      <= '0;
      out_valid_q <= 1'b0;
      su_go_q     <= 1'b0;
      su_op_q     <= SU_DIV;
    end else begin
      su_go_q <= su_go_d;
      // the send state reloads the register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_SEND)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (in_data_i.req_type)
              REQ_PCM: begin
                sq_sum_q <= sq_sum_q + {32'd0, mag_sq};
                n_samp_q <= n_samp_q + 32'd1;
                if (mag > peak_q) begin
                  peak_q <= mag;
                end
              end
              REQ_FRAME_OK: begin
                ok_q   <= ok_q + 32'd1;
                dsum_q <= dsum_q + {12'd0, in_data_i.decode_time_us};
                if (in_data_i.decode_time_us > dmax_q) begin
                  dmax_q <= in_data_i.decode_time_us;
                end
              end
              REQ_FRAME_ER: begin
                err_q     <= err_q + 32'd1;
                err_tot_q <= err_tot_q + 32'd1;
              end
              REQ_REPORT: begin
                sq_sum_q <= '0;
                n_samp_q <= '0;
                peak_q   <= '0;
                ok_q     <= '0;
                err_q    <= '0;
                dsum_q   <= '0;
                dmax_q   <= '0;
                priority if (n_samp_q != 32'd0) begin
                  su_op_q <= SU_DIV;
                  state_q <= ST_MEAN;
                end else if (ok_q != 32'd0) begin
                  su_op_q <= SU_DIV;
                  state_q <= ST_AVG;
                end else begin
                  state_q <= ST_SEND;
                end
              end
              REQ_CLEAR: begin
                sq_sum_q  <= '0;
                n_samp_q  <= '0;
                peak_q    <= '0;
                ok_q      <= '0;
                err_q     <= '0;
                err_tot_q <= '0;
                dsum_q    <= '0;
                dmax_q    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MEAN: begin
          if (su_stat.done) begin
            su_op_q <= SU_SQRT;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (su_stat.done) begin
            if (snap_ok_q != 32'd0) begin
              su_op_q <= SU_DIV;
              state_q <= ST_AVG;
            end else begin
              state_q <= ST_SEND;
            end
          end
        end
        ST_AVG: begin
          if (su_stat.done) begin
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload: snapshot, unit operands, result assembly
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_data_i.req_type == REQ_REPORT)) begin
          snap_ok_q                <= ok_q;
          snap_dsum_q              <= dsum_q;
          pend_q.rms_level         <= '0;
          pend_q.peak_level        <= peak_q;
          pend_q.ok_frames         <= ok_q;
          pend_q.err_frames        <= err_q;
          pend_q.err_frames_total  <= err_tot_q;
          pend_q.avg_decode_us     <= '0;
          pend_q.max_decode_us     <= dmax_q;
          if (n_samp_q != 32'd0) begin
            su_x_q <= sq_sum_q;
            su_d_q <= n_samp_q;
          end else begin
            su_x_q <= {32'd0, dsum_q};
            su_d_q <= ok_q;
          end
        end
      end
      ST_MEAN: begin
        if (su_stat.done) begin
          su_x_q <= su_res;
        end
      end
      ST_ROOT: begin
        if (su_stat.done) begin
          pend_q.rms_level <= rms_sat;
          su_x_q           <= {32'd0, snap_dsum_q};
          su_d_q           <= snap_ok_q;
        end
      end
      ST_AVG: begin
        if (su_stat.done) begin
          pend_q.avg_decode_us <= su_res[31:0];
        end
      end
      ST_SEND: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q <= pend_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // unit running means input is held off
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    su_stat.busy |-> in_stall_o)
    else $error("shift/subtract unit busy while input open");

  // a result only appears out of the send state
  a_out_from_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_SEND))
    else $error("output valid raised outside send state");

  // an accepted report closes the input on the next cycle
  a_report_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.req_type == REQ_REPORT)) |=> in_stall_o)
    else $error("report transfer did not hold off input");

  // the unit is only started when it is free
  a_go_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    su_go_q |-> !su_stat.busy)
    else $error("unit started while busy");

endmodule

// ----- hw/rtl/alfsm_shift_sub.sv -----
// Shared iterative shift/subtract unit: 64/32 restoring divide or 64-bit
// integer square root, one quotient or root bit per cycle. Uses alfsm_pkg.
module alfsm_shift_sub import alfsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  su_req_t     req_i,
  input  logic [63:0] x_i,
  input  logic [31:0] d_i,
  output su_stat_t    stat_o,
  output logic [63:0] res_o
);

  localparam logic [5:0] DivLast  = 6'(DivSteps - 1);
  localparam logic [5:0] SqrtLast = 6'(SqrtSteps - 1);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  su_op_e      op_q, op_d;
  logic [63:0] x_q, x_d;
  logic [31:0] d_q, d_d;
  logic [33:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [36:0] diff;
  logic        ge;

  always_comb begin
    if (op_q == SU_SQRT) begin
      rem_sh = {rem_q, x_q[63:62]};
      trial  = {2'b00, res_q[31:0], 2'b01};
    end else begin
      rem_sh = {1'b0, rem_q, x_q[63]};
      trial  = {4'b0000, d_q};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = ~diff[36];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    x_d    = x_q;
    d_d    = d_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (req_i.go && !busy_q) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == SU_SQRT) ? SqrtLast : DivLast;
      x_d    = x_i;
      d_d    = d_i;
      rem_d  = '0;
      res_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[33:0] : rem_sh[33:0];
      res_d = {res_q[62:0], ge};
      x_d   = (op_q == SU_SQRT) ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= SU_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

// ----- bench/audio_level_and_frame_stats_meter_tb.sv -----
// Self-checking bench for audio_level_and_frame_stats_meter: directed, pressure and random
// request streams, with an in-bench tally of the meter's state predicting every report.
// Depends on alfsm_pkg and the top-level RTL only.
module audio_level_and_frame_stats_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alfsm_pkg::*;

  localparam logic [2:0] ReqIgnoredLo = 3'd5;
  localparam logic [2:0] ReqIgnoredHi = 3'd7;
  localparam logic [19:0] DecodeMax   = 20'hFFFFF;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 200;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  audio_level_and_frame_stats_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t    request_q[$];
  out_item_t   report_q[$];
  int unsigned err_cnt = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned hold_requests = 0;

  // Tally of the meter's state
  logic [63:0] sq_sum    = '0;
  logic [31:0] n_samples = '0;
  logic [15:0] peak      = '0;
  logic [31:0] n_ok      = '0;
  logic [31:0] n_err     = '0;
  logic [31:0] n_err_all = '0;
  logic [31:0] dt_sum    = '0;
  logic [19:0] dt_max    = '0;

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic clear_interval_tallies();
    sq_sum    = '0;
    n_samples = '0;
    peak      = '0;
    n_ok      = '0;
    n_err     = '0;
    dt_sum    = '0;
    dt_max    = '0;
  endtask

  task automatic tally_request(in_item_t it);
    logic [16:0] mag;
    logic [63:0] root;
    out_item_t   rep;
    case (it.req_type)
      REQ_PCM: begin
        mag = it.pcm_sample[15] ? 17'h10000 - {1'b0, it.pcm_sample} : {1'b0, it.pcm_sample};
        sq_sum    = sq_sum + 64'(mag) * 64'(mag);
        n_samples = n_samples + 32'd1;
        if (mag > 17'(peak)) peak = mag[15:0];
      end
      REQ_FRAME_OK: begin
        n_ok   = n_ok + 32'd1;
        dt_sum = dt_sum + 32'(it.decode_time_us);
        if (it.decode_time_us > dt_max) dt_max = it.decode_time_us;
      end
      REQ_FRAME_ER: begin
        n_err     = n_err + 32'd1;
        n_err_all = n_err_all + 32'd1;
      end
      REQ_REPORT: begin
        rep  = '0;
        root = '0;
        if (n_samples != 0) root = floor_root(sq_sum / 64'(n_samples));
        rep.rms_level        = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
        rep.peak_level       = peak;
        rep.ok_frames        = n_ok;
        rep.err_frames       = n_err;
        rep.err_frames_total = n_err_all;
        rep.avg_decode_us    = (n_ok != 0) ? dt_sum / n_ok : 32'd0;
        rep.max_decode_us    = dt_max;
        report_q.push_back(rep);
        clear_interval_tallies();
      end
      REQ_CLEAR: begin
        clear_interval_tallies();
        n_err_all = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Monitor: input transfers feed the tally, output transfers are checked in order
  always @(posedge clk_i) begin
    out_item_t want;
    in_fire  <= rst_ni && in_valid_i && !in_stall_o;
    out_fire <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $error("report transfer with nothing expected");
          err_cnt++;
        end else begin
          want = report_q.pop_front();
          check_field("rms_level", 32'(want.rms_level), 32'(out_data_o.rms_level));
          check_field("peak_level", 32'(want.peak_level), 32'(out_data_o.peak_level));
          check_field("ok_frames", want.ok_frames, out_data_o.ok_frames);
          check_field("err_frames", want.err_frames, out_data_o.err_frames);
          check_field("err_frames_total", want.err_frames_total,
                      out_data_o.err_frames_total);
          check_field("avg_decode_us", want.avg_decode_us, out_data_o.avg_decode_us);
          check_field("max_decode_us", 32'(want.max_decode_us),
                      32'(out_data_o.max_decode_us));
        end
      end
      if (in_valid_i && !in_stall_o) tally_request(in_data_i);
    end
  end

  // Driver: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    if (in_fire) void'(request_q.pop_front());
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (!in_valid_i || in_fire) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0) begin
        nxt_valid = 1'b1;
        nxt_data  = request_q[0];
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  // Receiver: free-running stall pattern plus long hold-offs on request
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_phase = 0;

  always @(negedge clk_i) begin
    logic nxt_stall;
    if (hold_left == 0 && holds_done != hold_requests) begin
      hold_left = LongHold;
      holds_done++;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(10, 200);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      0:       nxt_stall = 1'b0;
      1:       nxt_stall = 1'($urandom_range(0, 1));
      default: nxt_stall = (stall_phase % 4) != 0;
    endcase
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end
    out_stall_i <= nxt_stall;
  end

  // Watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (in_fire || out_fire || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_item_t make_request(logic [2:0] req, logic [15:0] pcm,
                                            logic [19:0] dt);
    in_item_t it;
    it.req_type       = req;
    it.pcm_sample     = pcm;
    it.decode_time_us = dt;
    return it;
  endfunction

  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned r;
    it.pcm_sample     = 16'($urandom);
    it.decode_time_us = 20'($urandom);
    case ($urandom_range(0, 7))
      0: it.pcm_sample = 16'sh8000;
      1: it.pcm_sample = 16'sh7FFF;
      2: it.decode_time_us = DecodeMax;
      3: it.decode_time_us = 20'($urandom_range(0, 5000));
      default: ;
    endcase
    r = $urandom_range(0, 99);
    if (r < 55)      it.req_type = REQ_PCM;
    else if (r < 72) it.req_type = REQ_FRAME_OK;
    else if (r < 84) it.req_type = REQ_FRAME_ER;
    else if (r < 94) it.req_type = REQ_REPORT;
    else if (r < 97) it.req_type = REQ_CLEAR;
    else             it.req_type = 3'($urandom_range(ReqIgnoredLo, ReqIgnoredHi));
    return it;
  endfunction

  task automatic wait_quiet();
    while (request_q.size() != 0 || in_valid_i || report_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_item_t it;
    int unsigned counted;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty report, extreme samples and times, ignored codes, clears
    request_q.push_back(make_request(REQ_REPORT, 16'h0, 20'h0));
    request_q.push_back(make_request(REQ_PCM, 16'h8000, 20'h0));
    request_q.push_back(make_request(REQ_PCM, 16'h7FFF, DecodeMax));
    request_q.push_back(make_request(REQ_PCM, 16'h0000, 20'h0));
    request_q.push_back(make_request(REQ_PCM, 16'hFFFF, 20'h0));
    request_q.push_back(make_request(REQ_FRAME_OK, 16'hFFFF, 20'h0));
    request_q.push_back(make_request(REQ_FRAME_OK, 16'h0, DecodeMax));
    request_q.push_back(make_request(REQ_FRAME_ER, 16'h1234, 20'h5));
    request_q.push_back(make_request(REQ_REPORT, 16'hFFFF, DecodeMax));
    for (int k = ReqIgnoredLo; k <= ReqIgnoredHi; k++)
      request_q.push_back(make_request(3'(k), 16'h8000, DecodeMax));
    request_q.push_back(make_request(REQ_PCM, 16'h0001, 20'h0));
    request_q.push_back(make_request(REQ_FRAME_ER, 16'h0, 20'h0));
    request_q.push_back(make_request(REQ_REPORT, 16'h0, 20'h0));
    request_q.push_back(make_request(REQ_CLEAR, 16'h7FFF, DecodeMax));
    request_q.push_back(make_request(REQ_REPORT, 16'h0, 20'h0));
    request_q.push_back(make_request(REQ_FRAME_OK, 16'h0, 20'd5));
    request_q.push_back(make_request(REQ_FRAME_OK, 16'h0, 20'd6));
    request_q.push_back(make_request(REQ_PCM, 16'd3, 20'h0));
    request_q.push_back(make_request(REQ_PCM, 16'hFFFC, 20'h0));
    request_q.push_back(make_request(REQ_REPORT, 16'h0, 20'h0));
    wait_quiet();

    // Long receiver hold-off with reports queued behind it, so input backs up
    hold_requests++;
    for (int k = 0; k < 60; k++) begin
      it = random_request();
      if (k % 5 == 4) it.req_type = REQ_REPORT;
      request_q.push_back(it);
    end
    wait_quiet();

    // Random traffic in chunks, pausing for all reports between chunks
    counted = 0;
    while (counted < 960) begin
      for (int k = 0; k < 240; k++) begin
        it = random_request();
        counted++;
        request_q.push_back(it);
      end
      wait_quiet();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
